### src/sm83_alu_unit_assert.svh
// Assertion macros used by the ALU unit.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef SM83_ALU_UNIT_ASSERT_SVH
`define SM83_ALU_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM83_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sm83_alu_pkg.sv
`timescale 1ns / 1ps

package sm83_alu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD       = 5'd0,
    CMD_ADC       = 5'd1,
    CMD_SUB       = 5'd2,
    CMD_SBC       = 5'd3,
    CMD_AND       = 5'd4,
    CMD_XOR       = 5'd5,
    CMD_OR        = 5'd6,
    CMD_CP        = 5'd7,
    CMD_INC8      = 5'd8,
    CMD_DEC8      = 5'd9,
    CMD_INC16     = 5'd10,
    CMD_DEC16     = 5'd11,
    CMD_ADD16     = 5'd12,
    CMD_ADD_SP_E8 = 5'd13,
    CMD_DAA       = 5'd14,
    CMD_CPL       = 5'd15,
    CMD_SCF       = 5'd16,
    CMD_CCF       = 5'd17,
    CMD_RLCA      = 5'd18,
    CMD_RRCA      = 5'd19,
    CMD_RLA       = 5'd20,
    CMD_RRA       = 5'd21,
    CMD_CB        = 5'd22
  } cmd_t;

  // Upper two bits of a CB opcode byte.
  typedef enum logic [1:0] {
    CB_SHIFT = 2'd0,
    CB_BIT   = 2'd1,
    CB_RES   = 2'd2,
    CB_SET   = 2'd3
  } cb_group_t;

  // Bits 5:3 of a CB opcode byte within the shift group.
  typedef enum logic [2:0] {
    CB_RLC  = 3'd0,
    CB_RRC  = 3'd1,
    CB_RL   = 3'd2,
    CB_RR   = 3'd3,
    CB_SLA  = 3'd4,
    CB_SRA  = 3'd5,
    CB_SWAP = 3'd6,
    CB_SRL  = 3'd7
  } cb_shift_t;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [3:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_back;
  } alu_rsp_t;

  function automatic logic [3:0] mk_flags(input logic z, input logic n,
                                          input logic h, input logic c);
    return {z, n, h, c};
  endfunction

endpackage

### src/sm83_alu_core.sv
`timescale 1ns / 1ps

module sm83_alu_core
  import sm83_alu_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [15:0] a16;
  logic [15:0] b16;
  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        zin;
  logic        nin;
  logic        hin;
  logic        t_add;
  logic        t_sub;
  logic [8:0]  sum8;
  logic [4:0]  half_add;
  logic [8:0]  diff8;
  logic [4:0]  half_sub;
  logic [16:0] sum16;
  logic [12:0] half16;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_carry;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_res;
  logic [2:0]  cb_sel;
  logic [1:0]  cb_grp;
  logic [7:0]  cb_mask;
  logic [7:0]  cb_rot;
  logic        cb_c;
  logic [7:0]  r8;
  logic [15:0] r;
  logic [3:0]  f;
  logic        wb;

  assign a16 = req.operand_a;
  assign b16 = req.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];
  assign cin = req.flags_in[FLAG_C];
  assign zin = req.flags_in[FLAG_Z];
  assign nin = req.flags_in[FLAG_N];
  assign hin = req.flags_in[FLAG_H];

  assign t_add = (req.command == CMD_ADC) & cin;
  assign t_sub = (req.command == CMD_SBC) & cin;

  assign sum8     = {1'b0, a} + {1'b0, b} + {8'd0, t_add};
  assign half_add = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t_add};
  // Bit 8 of the nine-bit difference is the borrow out of the byte.
  assign diff8    = {1'b0, a} - {1'b0, b} - {8'd0, t_sub};
  assign half_sub = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t_sub};

  assign sum16  = {1'b0, a16} + {1'b0, b16};
  assign half16 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  // SP plus a signed byte: the flags come from the unsigned low-byte add.
  assign sp_sum   = a16 + {{8{b[7]}}, b};
  assign sp_half  = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_carry = {1'b0, a16[7:0]} + {1'b0, b};

  assign daa_lo  = hin | (~nin & (a[3:0] > DAA_LO_LIMIT));
  assign daa_hi  = cin | (~nin & (a > DAA_HI_LIMIT));
  assign daa_adj = (daa_lo ? DAA_LO_ADJ : 8'h00) | (daa_hi ? DAA_HI_ADJ : 8'h00);
  assign daa_res = nin ? (a - daa_adj) : (a + daa_adj);

  assign cb_sel  = b[5:3];
  assign cb_grp  = b[7:6];
  assign cb_mask = 8'd1 << cb_sel;

  always_comb begin
    unique case (cb_sel)
      CB_RLC: begin
        cb_rot = {a[6:0], a[7]};
        cb_c   = a[7];
      end
      CB_RRC: begin
        cb_rot = {a[0], a[7:1]};
        cb_c   = a[0];
      end
      CB_RL: begin
        cb_rot = {a[6:0], cin};
        cb_c   = a[7];
      end
      CB_RR: begin
        cb_rot = {cin, a[7:1]};
        cb_c   = a[0];
      end
      CB_SLA: begin
        cb_rot = {a[6:0], 1'b0};
        cb_c   = a[7];
      end
      CB_SRA: begin
        cb_rot = {a[7], a[7:1]};
        cb_c   = a[0];
      end
      CB_SWAP: begin
        cb_rot = {a[3:0], a[7:4]};
        cb_c   = 1'b0;
      end
      CB_SRL: begin
        cb_rot = {1'b0, a[7:1]};
        cb_c   = a[0];
      end
    endcase
  end

  always_comb begin
    r8 = 8'h00;
    r  = 16'h0000;
    f  = req.flags_in;
    wb = 1'b1;
    unique case (req.command)
      CMD_ADD, CMD_ADC: begin
        r8 = sum8[7:0];
        f  = mk_flags(r8 == 8'h00, 1'b0, half_add[4], sum8[8]);
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        r8 = diff8[7:0];
        f  = mk_flags(r8 == 8'h00, 1'b1, half_sub[4], diff8[8]);
        wb = (req.command != CMD_CP);
      end
      CMD_AND: begin
        r8 = a & b;
        f  = mk_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      CMD_XOR: begin
        r8 = a ^ b;
        f  = mk_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_OR: begin
        r8 = a | b;
        f  = mk_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_INC8: begin
        r8 = a + 8'd1;
        f  = mk_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
      end
      CMD_DEC8: begin
        r8 = a - 8'd1;
        f  = mk_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
      end
      CMD_INC16: begin
        r = a16 + 16'd1;
      end
      CMD_DEC16: begin
        r = a16 - 16'd1;
      end
      CMD_ADD16: begin
        r = sum16[15:0];
        f = mk_flags(zin, 1'b0, half16[12], sum16[16]);
      end
      CMD_ADD_SP_E8: begin
        r = sp_sum;
        f = mk_flags(1'b0, 1'b0, sp_half[4], sp_carry[8]);
      end
      CMD_DAA: begin
        r8 = daa_res;
        f  = mk_flags(r8 == 8'h00, nin, 1'b0, daa_hi);
      end
      CMD_CPL: begin
        r8 = ~a;
        f  = mk_flags(zin, 1'b1, 1'b1, cin);
      end
      CMD_SCF: begin
        r8 = a;
        f  = mk_flags(zin, 1'b0, 1'b0, 1'b1);
      end
      CMD_CCF: begin
        r8 = a;
        f  = mk_flags(zin, 1'b0, 1'b0, ~cin);
      end
      CMD_RLCA: begin
        r8 = {a[6:0], a[7]};
        f  = mk_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      CMD_RRCA: begin
        r8 = {a[0], a[7:1]};
        f  = mk_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      CMD_RLA: begin
        r8 = {a[6:0], cin};
        f  = mk_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      CMD_RRA: begin
        r8 = {cin, a[7:1]};
        f  = mk_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      CMD_CB: begin
        unique case (cb_grp)
          CB_SHIFT: begin
            r8 = cb_rot;
            f  = mk_flags(r8 == 8'h00, 1'b0, 1'b0, cb_c);
          end
          CB_BIT: begin
            r8 = a;
            f  = mk_flags(~|(a & cb_mask), 1'b0, 1'b1, cin);
            wb = 1'b0;
          end
          CB_RES: begin
            r8 = a & ~cb_mask;
          end
          CB_SET: begin
            r8 = a | cb_mask;
          end
        endcase
      end
      default: begin
        // Codes with no operation give a zero result and are not stored.
        wb = 1'b0;
      end
    endcase
    if (req.command != CMD_INC16 && req.command != CMD_DEC16 &&
        req.command != CMD_ADD16 && req.command != CMD_ADD_SP_E8) begin
      r = {8'h00, r8};
    end
  end

  assign rsp.result     = r;
  assign rsp.flags_out  = f;
  assign rsp.write_back = wb;

endmodule

### src/sm83_alu_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    command, operand_a, operand_b, flags_in
// output    out_valid / out_ready  result, flags_out, write_back
//
// One request is taken per cycle while in_ready is high; after acceptance its
// result register captures the ALU logic fed by the input register unless stalled.
// Reset empties both register stages; payload registers are left as they are.
// A stalled output holds its result, and the input register keeps accepting
// while it is empty or the result register is empty or being drained.
module sm83_alu_unit
  import sm83_alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  command,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [3:0]  flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result,
  output logic [3:0]  flags_out,
  output logic        write_back
);

`include "sm83_alu_unit_assert.svh"

  logic     s1_valid;
  alu_req_t s1_req;
  alu_rsp_t rsp;
  alu_rsp_t rsp_q;
  logic     s2_ready;

  assign s2_ready = ~out_valid | out_ready;
  assign in_ready = ~s1_valid | s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= '{command: command, operand_a: operand_a,
                  operand_b: operand_b, flags_in: flags_in};
    end
    if (s1_valid && s2_ready) begin
      rsp_q <= rsp;
    end
  end

  sm83_alu_core u_core (
    .req (s1_req),
    .rsp (rsp)
  );

  assign result     = rsp_q.result;
  assign flags_out  = rsp_q.flags_out;
  assign write_back = rsp_q.write_back;

  `SM83_ASSERT_NEXT(a_capture, in_valid && in_ready, s1_valid,
                    "accepted request did not reach the input register")
  `SM83_ASSERT_NEXT(a_hold, s1_valid && !s2_ready, s1_valid && $stable(s1_req),
                    "stalled request in the input register was lost or changed")
  `SM83_ASSERT_NEXT(a_result, s1_valid && s2_ready, out_valid && rsp_q == $past(rsp),
                    "result register does not hold the computed result")
  `SM83_ASSERT_SAME(a_ready, !in_ready, s1_valid && out_valid && !out_ready,
                    "input stalled while the pipeline could advance")

endmodule
